// File: rtl/imupd_pkg.sv
// Shared types and constants for the IMU packet deframer.
// Holds the framing bytes, the status codes and the byte-wide CRC-32 update.
// No dependencies.
`timescale 1ns / 1ps

package imupd_pkg;

    // Framing bytes
    localparam logic [7:0] START_BYTE = 8'hFE;
    localparam logic [7:0] HDR_BYTE1  = 8'h81;
    localparam logic [7:0] HDR_BYTE2  = 8'hFF;
    localparam logic [7:0] HDR_BYTE3  = 8'h55;
    localparam logic [7:0] STATUS_OK  = 8'h77;

    // Byte positions inside a packet
    localparam int unsigned POS_W      = 6;
    localparam logic [5:0] PACKET_LAST = 6'd35;
    localparam logic [5:0] CRC_SPAN    = 6'd32;
    localparam logic [5:0] FIRST_WORD  = 6'd4;
    localparam logic [5:0] WORDS_END   = 6'd28;
    localparam logic [5:0] STATUS_POS  = 6'd28;
    localparam int unsigned NUM_WORDS  = 6;

    // CRC-32/MPEG-2
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Packet status codes
    localparam logic [1:0] PKT_GOOD       = 2'd0;
    localparam logic [1:0] PKT_CRC_BAD    = 2'd1;
    localparam logic [1:0] PKT_STATUS_BAD = 2'd2;

    // Control from the framer to the CRC unit
    typedef struct packed {
        logic restart;  // back to all ones
        logic seed;     // feed byte onto the initial value
        logic feed;     // feed byte onto the running value
    } crc_ctrl_t;

    // One byte through the MSB-first CRC, eight shift steps
    function automatic logic [31:0] crc_feed(input logic [31:0] crc_in,
                                              input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {data, 24'h0};
        for (int i = 0; i < 8; i++) begin
            if (c[31]) begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/imu_packet_deframer_crc32.sv
// IMU packet deframer: start/header hunt, 36-byte packet capture, CRC-32 check.
// The result is registered: it appears in the cycle after the last byte (byte 35) of a packet is taken.
// Throughput: one byte per cycle; the only stall is the last byte of a packet while
// the previous result is still held in the output register.
// Reset (synchronous, aresetn low): hunting for the start byte, CRC all ones, no result.
// Depends on imupd_pkg and imupd_crc_unit.
`timescale 1ns / 1ps

module imu_packet_deframer_crc32
    import imupd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_gyro_x_bits,
    output logic [31:0] m_gyro_y_bits,
    output logic [31:0] m_gyro_z_bits,
    output logic [31:0] m_accel_x_bits,
    output logic [31:0] m_accel_y_bits,
    output logic [31:0] m_accel_z_bits,
    output logic [1:0]  m_packet_status
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      rx_crc_reg, rx_crc_next;
    logic             stat_good_reg, stat_good_next;
    logic [31:0]      words_reg [NUM_WORDS];
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      out_words_reg [NUM_WORDS];
    logic [1:0]       out_status_reg;

    logic             in_acc;
    logic [POS_W-1:0] pos_eff;
    logic             hdr_ok;
    logic [7:0]       hdr_want;
    logic             in_words;
    logic [POS_W-1:0] word_off;
    logic [2:0]       word_idx;
    logic             pkt_done;
    logic [1:0]       status_next;
    logic [31:0]      crc_run;
    crc_ctrl_t        crc_ctrl;

    // Positions beyond the packet count as hunting
    assign pos_eff = (pos_reg > PACKET_LAST) ? '0 : pos_reg;

    // Last byte may only enter when the output register can take its result
    assign s_ready = !m_valid_reg || m_ready || (pos_eff != PACKET_LAST);
    assign in_acc  = s_valid && s_ready;

    // Header byte expected at positions 1..3
    always_comb begin
        unique case (pos_eff[1:0])
            2'd1:    hdr_want = HDR_BYTE1;
            2'd2:    hdr_want = HDR_BYTE2;
            default: hdr_want = HDR_BYTE3;
        endcase
    end
    assign hdr_ok = (pos_eff >= FIRST_WORD) || (s_rx_byte == hdr_want);

    assign in_words = (pos_eff >= FIRST_WORD) && (pos_eff < WORDS_END);
    assign word_off = pos_eff - FIRST_WORD;
    assign word_idx = word_off[4:2];
    assign pkt_done = in_acc && (pos_eff == PACKET_LAST);

    // CRC control
    always_comb begin
        crc_ctrl = '0;
        if (in_acc) begin
            if (pos_eff == '0) begin
                crc_ctrl.seed    = (s_rx_byte == START_BYTE);
                crc_ctrl.restart = (s_rx_byte != START_BYTE);
            end else if (!hdr_ok || pos_eff == PACKET_LAST) begin
                crc_ctrl.restart = 1'b1;
            end else begin
                crc_ctrl.feed = (pos_eff < CRC_SPAN);
            end
        end
    end

    imupd_crc_unit u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (crc_ctrl),
        .data    (s_rx_byte),
        .crc     (crc_run)
    );

    // Framing state
    always_comb begin
        pos_next       = pos_reg;
        rx_crc_next    = rx_crc_reg;
        stat_good_next = stat_good_reg;
        if (in_acc) begin
            if (pos_eff == '0) begin
                if (s_rx_byte == START_BYTE) begin
                    pos_next       = POS_W'(1);
                    rx_crc_next    = '0;
                    stat_good_next = 1'b0;
                end else begin
                    pos_next = '0;
                end
            end else if (!hdr_ok) begin
                pos_next = '0;
            end else begin
                if (pos_eff == STATUS_POS) begin
                    stat_good_next = (s_rx_byte == STATUS_OK);
                end
                if (pos_eff >= CRC_SPAN) begin
                    rx_crc_next = {rx_crc_reg[23:0], s_rx_byte};
                end
                pos_next = (pos_eff == PACKET_LAST) ? '0 : pos_eff + POS_W'(1);
            end
        end
    end

    // Result status: CRC mismatch takes priority
    always_comb begin
        if (rx_crc_next != crc_run) begin
            status_next = PKT_CRC_BAD;
        end else if (!stat_good_reg) begin
            status_next = PKT_STATUS_BAD;
        end else begin
            status_next = PKT_GOOD;
        end
    end

    assign m_valid_next = pkt_done ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            rx_crc_reg    <= '0;
            stat_good_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            rx_crc_reg    <= rx_crc_next;
            stat_good_reg <= stat_good_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Sample words: shift bytes in big-endian
    always_ff @(posedge aclk) begin
        if (in_acc && in_words) begin
            words_reg[word_idx] <= {words_reg[word_idx][23:0], s_rx_byte};
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (pkt_done) begin
            for (int k = 0; k < NUM_WORDS; k++) begin
                out_words_reg[k] <= words_reg[k];
            end
            out_status_reg <= status_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_gyro_x_bits   = out_words_reg[0];
    assign m_gyro_y_bits   = out_words_reg[1];
    assign m_gyro_z_bits   = out_words_reg[2];
    assign m_accel_x_bits  = out_words_reg[3];
    assign m_accel_y_bits  = out_words_reg[4];
    assign m_accel_z_bits  = out_words_reg[5];
    assign m_packet_status = out_status_reg;

    // Checks
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= PACKET_LAST)
        else $error("byte position left the packet range");

    a_crc_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg == '0) |-> (crc_run == CRC_INIT))
        else $error("CRC not at initial value while hunting");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(pkt_done))
        else $error("result raised without a finished packet");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_status_reg == PKT_GOOD || out_status_reg == PKT_CRC_BAD
                         || out_status_reg == PKT_STATUS_BAD))
        else $error("illegal packet status");

endmodule

// File: rtl/imupd_crc_unit.sv
// Running CRC-32 register, updated one byte per accepted item.
// Depends on imupd_pkg for the control struct and the byte update.
`timescale 1ns / 1ps

module imupd_crc_unit
    import imupd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  crc_ctrl_t   ctrl,
    input  logic [7:0]  data,
    output logic [31:0] crc
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;

    // Next value: restart wins, then seeding from a start byte, then feed
    always_comb begin
        crc_next = crc_reg;
        if (ctrl.restart) begin
            crc_next = CRC_INIT;
        end else if (ctrl.seed) begin
            crc_next = crc_feed(CRC_INIT, data);
        end else if (ctrl.feed) begin
            crc_next = crc_feed(crc_reg, data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule
